// ===== design/banked_window_address_translator_unit_assert.svh =====
// Assertion macros for the banked window address translator.
// Each expects signals named clock and reset in scope.
`ifndef BANKED_WINDOW_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`define BANKED_WINDOW_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BWAT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bwat assertion failed");

// next-cycle implication
`define BWAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bwat assertion failed");

`endif

// ===== design/bwat_pkg.sv =====
// ----------------------------------------------------------------------------
// bwat_pkg
// Shared types and constants for the banked window address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package bwat_pkg;

   localparam int RAM_BYTES     = 32768;
   localparam int RAM_AW        = $clog2(RAM_BYTES);
   localparam int EXT_ADDR_BITS = 26;
   localparam int EXT_W         = 26;
   localparam int EXT_KEEP      = (EXT_ADDR_BITS < EXT_W) ? EXT_ADDR_BITS : EXT_W;
   localparam logic [EXT_W-1:0] EXT_MASK = EXT_W'((64'd1 << EXT_KEEP) - 64'd1);

   localparam int CSR_IW = 3;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_IRQ_BANK     = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_IRQ_ENABLE   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_PROGRAM_BANK = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DATA_BANK    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_B_BANK       = 3'd4;

   // implemented bank bits
   localparam logic [15:0] PROG_BANK_MASK = 16'h87FF;
   localparam logic [15:0] DATA_BANK_MASK = 16'h8FFF;
   localparam logic [15:0] B_BANK_MASK    = 16'h9FFF;

   // route codes
   localparam logic [1:0] ROUTE_RAM    = 2'd0;
   localparam logic [1:0] ROUTE_EXT    = 2'd1;
   localparam logic [1:0] ROUTE_PERIPH = 2'd2;

   localparam logic [15:0] PERIPH_END = 16'h0080;
   localparam logic [15:0] DIRECT_END = 16'h2000;

   typedef struct packed {
      logic [15:0] irq_bank;
      logic        irq_enable;
      logic [15:0] program_bank;
      logic [15:0] data_bank;
      logic [15:0] b_bank;
   } bank_cfg_type;

   typedef struct packed {
      logic [1:0]        route;
      logic              ram_hit;
      logic [RAM_AW-1:0] ram_index;
      logic [EXT_W-1:0]  ext_address;
   } xlate_type;

endpackage

`default_nettype wire

// ===== design/banked_window_address_translator_unit.sv =====
// ----------------------------------------------------------------------------
// banked_window_address_translator_unit
// Maps CPU byte accesses through data, program and B bank windows onto an
// internal 32K SRAM, the external bus or the peripheral space.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  req      start / busy         command, address, write_data, in_service
//  rsp      rsp_valid (strobe)   route, ext_address, read_data, ext_write
//  csr      csr_valid/csr_ready  csr_index, csr_data
//
// One access a cycle while busy is low; its result strobes the cycle after
// acceptance, set by the registered read of the SRAM port.
// After reset the SRAM is swept to zero, one byte a cycle, with busy high.
// CSR beats are taken at all times.
// The result side has no stall.
`default_nettype none

module banked_window_address_translator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [15:0]                   req_address,
   input  wire logic [7:0]                    req_write_data,
   input  wire logic                          req_in_service,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_route,
   output logic [bwat_pkg::EXT_W-1:0]         rsp_ext_address,
   output logic [7:0]                         rsp_read_data,
   output logic                               rsp_ext_write,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bwat_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [15:0]                   csr_data
);
   import bwat_pkg::*;

   bank_cfg_type      cfg_ff;
   xlate_type         xlate;

   logic              clr_active_ff;
   logic [RAM_AW-1:0] clr_idx_ff;

   logic              accept;
   logic              mem_we;
   logic [RAM_AW-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [7:0]        mem [RAM_BYTES];
   logic [7:0]        rd_ff;

   logic              rsp_valid_ff;
   logic [1:0]        route_ff;
   logic [EXT_W-1:0]  ext_ff;
   logic              ext_write_ff;
   logic              ram_read_ff;

   assign busy      = clr_active_ff | reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IRQ_BANK:     cfg_ff.irq_bank     <= csr_data & PROG_BANK_MASK;
            CSR_IRQ_ENABLE:   cfg_ff.irq_enable   <= csr_data[0];
            CSR_PROGRAM_BANK: cfg_ff.program_bank <= csr_data & PROG_BANK_MASK;
            CSR_DATA_BANK:    cfg_ff.data_bank    <= csr_data & DATA_BANK_MASK;
            CSR_B_BANK:       cfg_ff.b_bank       <= csr_data & B_BANK_MASK;
            default: ;
         endcase
      end
   end

   bwat_decode u_decode (
      .address    (req_address),
      .in_service (req_in_service),
      .cfg        (cfg_ff),
      .xlate      (xlate)
   );

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (&clr_idx_ff) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = xlate.ram_index;
      mem_wd = req_write_data;
      if (clr_active_ff && !reset) begin
         mem_we = 1'b1;
         mem_wa = clr_idx_ff;
         mem_wd = '0;
      end else if (accept && xlate.ram_hit && req_command) begin
         mem_we = 1'b1;
      end
   end

   // SRAM: one write, one registered read; a read after a write in the
   // previous cycle sees the new byte
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_ff <= mem[xlate.ram_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         route_ff     <= xlate.route;
         ext_ff       <= xlate.ext_address;
         ext_write_ff <= (xlate.route == ROUTE_EXT) & req_command;
         ram_read_ff  <= xlate.ram_hit & ~req_command;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_route       = route_ff;
   assign rsp_ext_address = ext_ff;
   assign rsp_ext_write   = ext_write_ff;
   assign rsp_read_data   = ram_read_ff ? rd_ff : 8'd0;

endmodule

`default_nettype wire

// ===== design/bwat_decode.sv =====
// ----------------------------------------------------------------------------
// bwat_decode
// Window decode: picks the bank for an address and forms RAM index or
// external address.
// ----------------------------------------------------------------------------
`default_nettype none

module bwat_decode (
   input  wire logic [15:0]          address,
   input  wire logic                 in_service,
   input  wire bwat_pkg::bank_cfg_type cfg,
   output bwat_pkg::xlate_type       xlate
);
   import bwat_pkg::*;

   logic [15:0] bank;
   logic [31:0] ext_full;

   always_comb begin
      bank     = '0;
      ext_full = '0;
      if (address[15]) begin
         bank     = cfg.data_bank;
         ext_full = {1'b0, bank, address[14:0]};
      end else if (address[14]) begin
         bank     = (in_service && cfg.irq_enable) ? cfg.irq_bank : cfg.program_bank;
         ext_full = {2'b0, bank, address[13:0]};
      end else begin
         bank     = cfg.b_bank;
         ext_full = {3'b0, bank, address[12:0]};
      end

      // every window's RAM base plus offset collapses to the low address bits
      xlate.ram_index   = address[RAM_AW-1:0];
      xlate.ext_address = '0;
      if (address < PERIPH_END) begin
         xlate.route   = ROUTE_PERIPH;
         xlate.ram_hit = 1'b0;
      end else if (address < DIRECT_END) begin
         xlate.route   = ROUTE_RAM;
         xlate.ram_hit = 1'b1;
      end else if (bank[15]) begin
         xlate.route   = ROUTE_RAM;
         xlate.ram_hit = 1'b1;
      end else begin
         xlate.route       = ROUTE_EXT;
         xlate.ram_hit     = 1'b0;
         xlate.ext_address = ext_full[EXT_W-1:0] & EXT_MASK;
      end
   end

endmodule

`default_nettype wire

// ===== design/bwat_checker.sv =====
// ----------------------------------------------------------------------------
// bwat_checker
// Port-level checks on the translator's result timing and payload.
// ----------------------------------------------------------------------------
`default_nettype none

`include "banked_window_address_translator_unit_assert.svh"

module bwat_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [1:0]                  rsp_route,
   input wire logic [bwat_pkg::EXT_W-1:0]  rsp_ext_address,
   input wire logic [7:0]                  rsp_read_data,
   input wire logic                        rsp_ext_write
);
   import bwat_pkg::*;

   `BWAT_ASSERT_NEXT(a_rsp_follows_accept, start && !busy, rsp_valid)
   `BWAT_ASSERT_IMPL(a_rsp_has_accept, rsp_valid, $past(start && !busy))
   `BWAT_ASSERT_IMPL(a_non_ext_clean, rsp_valid && rsp_route != ROUTE_EXT, rsp_ext_address == '0 && !rsp_ext_write)
   `BWAT_ASSERT_IMPL(a_non_ram_no_data, rsp_valid && rsp_route != ROUTE_RAM, rsp_read_data == 8'd0)

endmodule

bind banked_window_address_translator_unit bwat_checker u_bwat_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_route       (rsp_route),
   .rsp_ext_address (rsp_ext_address),
   .rsp_read_data   (rsp_read_data),
   .rsp_ext_write   (rsp_ext_write)
);

`default_nettype wire

// ===== verif/banked_window_address_translator_unit_checker.sv =====
// ----------------------------------------------------------------------------
// banked_window_address_translator_unit_checker
// Watches the access, result and register channels of the bank window
// translator. It keeps its own bank registers and SRAM image and works out
// each access's result at acceptance. Each result beat is compared, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module banked_window_address_translator_unit_checker
   import bwat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic              req_command,
   input  wire logic [15:0]       req_address,
   input  wire logic [7:0]        req_write_data,
   input  wire logic              req_in_service,
   input  wire logic              rsp_valid,
   input  wire logic [1:0]        rsp_route,
   input  wire logic [EXT_W-1:0]  rsp_ext_address,
   input  wire logic [7:0]        rsp_read_data,
   input  wire logic              rsp_ext_write,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [15:0]       csr_data,
   output int                     mismatches,
   output int                     pending
);

   typedef struct packed {
      logic [1:0]       route;
      logic [EXT_W-1:0] ext_address;
      logic [7:0]       read_data;
      logic             ext_write;
   } access_result_type;

   typedef struct {
      access_result_type result;
      logic [15:0]       address;
      logic              command;
   } access_entry_type;

   logic [7:0]       sram_image [RAM_BYTES];
   bank_cfg_type     banks;
   access_entry_type expected_q [$];
   int               error_total;

   task automatic flag_error(string msg);
      $display("%0t: %s", $time, msg);
      error_total++;
   endtask

   // updates the SRAM image on writes, so call once per accepted access
   function automatic access_result_type translate_access(logic is_write, logic [15:0] addr,
                                                          logic [7:0] wdata, logic servicing);
      access_result_type res;
      logic [15:0]       bank;
      logic [15:0]       offset;
      logic [15:0]       base;
      int                shift;
      logic              use_ram;
      logic [RAM_AW-1:0] ram_idx;
      logic [63:0]       wide;
      res     = '0;
      use_ram = 1'b0;
      ram_idx = '0;
      if (addr < PERIPH_END) begin
         res.route = ROUTE_PERIPH;
      end else if (addr < DIRECT_END) begin
         use_ram   = 1'b1;
         ram_idx   = addr[RAM_AW-1:0];
         res.route = ROUTE_RAM;
      end else begin
         if (addr[15]) begin
            bank   = banks.data_bank;
            offset = {1'b0, addr[14:0]};
            shift  = 15;
            base   = 16'h0000;
         end else if (addr[14]) begin
            bank   = (servicing && banks.irq_enable) ? banks.irq_bank : banks.program_bank;
            offset = {2'b0, addr[13:0]};
            shift  = 14;
            base   = 16'h4000;
         end else begin
            bank   = banks.b_bank;
            offset = {3'b0, addr[12:0]};
            shift  = 13;
            base   = 16'h2000;
         end
         if (bank[15]) begin
            use_ram   = 1'b1;
            ram_idx   = RAM_AW'(base | offset);
            res.route = ROUTE_RAM;
         end else begin
            wide            = (64'(bank) << shift) | 64'(offset);
            res.route       = ROUTE_EXT;
            res.ext_address = EXT_W'(wide) & EXT_MASK;
            res.ext_write   = is_write;
         end
      end
      if (use_ram) begin
         if (is_write) sram_image[ram_idx] = wdata;
         else res.read_data = sram_image[ram_idx];
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      access_result_type seen;
      access_entry_type  want;
      if (reset) begin
         foreach (sram_image[i]) sram_image[i] = 8'h00;
         banks       = '0;
         expected_q  = {};
         error_total = 0;
      end else begin
         // result beats first: a new access accepted this edge answers later
         if (rsp_valid) begin
            seen.route       = rsp_route;
            seen.ext_address = rsp_ext_address;
            seen.read_data   = rsp_read_data;
            seen.ext_write   = rsp_ext_write;
            if (expected_q.size() == 0) begin
               flag_error($sformatf("result beat with nothing outstanding: %p", seen));
            end else begin
               want = expected_q.pop_front();
               if (seen.route !== want.result.route)
                  flag_error($sformatf("addr %h cmd %0d: route %0d, expected %0d",
                     want.address, want.command, seen.route, want.result.route));
               if (seen.ext_address !== want.result.ext_address)
                  flag_error($sformatf("addr %h cmd %0d: ext_address %h, expected %h",
                     want.address, want.command, seen.ext_address, want.result.ext_address));
               if (seen.read_data !== want.result.read_data)
                  flag_error($sformatf("addr %h cmd %0d: read_data %h, expected %h",
                     want.address, want.command, seen.read_data, want.result.read_data));
               if (seen.ext_write !== want.result.ext_write)
                  flag_error($sformatf("addr %h cmd %0d: ext_write %0d, expected %0d",
                     want.address, want.command, seen.ext_write, want.result.ext_write));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IRQ_BANK:     banks.irq_bank     = csr_data & PROG_BANK_MASK;
               CSR_IRQ_ENABLE:   banks.irq_enable   = csr_data[0];
               CSR_PROGRAM_BANK: banks.program_bank = csr_data & PROG_BANK_MASK;
               CSR_DATA_BANK:    banks.data_bank    = csr_data & DATA_BANK_MASK;
               CSR_B_BANK:       banks.b_bank       = csr_data & B_BANK_MASK;
               default: ;
            endcase
         end
         if (start && !busy) begin
            want.address = req_address;
            want.command = req_command;
            want.result  = translate_access(req_command, req_address, req_write_data,
                                            req_in_service);
            expected_q.push_back(want);
         end
      end
      pending    <= expected_q.size();
      mismatches <= error_total;
   end

endmodule

// ===== verif/banked_window_address_translator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// banked_window_address_translator_unit_tb
// Drives CPU accesses and bank register writes into the translator: a short
// directed run over window edges, bank extremes and SRAM aliasing, then
// random phases with fresh bank settings and varying sender gaps. Checking is
// done by the checker instance; this module only makes stimulus.
// ----------------------------------------------------------------------------
module banked_window_address_translator_unit_tb;
   import bwat_pkg::*;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // indexes with no register behind them
   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = 3'd7;

   localparam int POOL_DEPTH = 16;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              req_command    = 1'b0;
   logic [15:0]       req_address    = '0;
   logic [7:0]        req_write_data = '0;
   logic              req_in_service = 1'b0;
   logic              csr_valid      = 1'b0;
   logic [CSR_IW-1:0] csr_index      = '0;
   logic [15:0]       csr_data       = '0;
   logic              busy;
   logic              rsp_valid;
   logic [1:0]        rsp_route;
   logic [EXT_W-1:0]  rsp_ext_address;
   logic [7:0]        rsp_read_data;
   logic              rsp_ext_write;
   logic              csr_ready;
   int                mismatches;
   int                pending;

   logic [15:0] recent_addr [POOL_DEPTH];
   int          recent_fill = 0;
   int          recent_put  = 0;
   int          idle_pct [3] = '{13, 59, 0};

   banked_window_address_translator_unit i_dut (.*);

   banked_window_address_translator_unit_checker i_checker (.*);

   always #6 clock = ~clock;

   initial begin
      #(12 * 400000);
      $display("banked_window_address_translator_unit_tb NOT OK");
      $finish;
   end

   // holds start low until every outstanding result beat has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // leaves start high; the caller lowers it or drives the next beat
   task automatic send_access(logic cmd, logic [15:0] addr, logic [7:0] wdata, logic svc);
      start          <= 1'b1;
      req_command    <= cmd;
      req_address    <= addr;
      req_write_data <= wdata;
      req_in_service <= svc;
      @(posedge clock);
      while (busy) @(posedge clock);
      recent_addr[recent_put] = addr;
      recent_put = (recent_put + 1) % POOL_DEPTH;
      if (recent_fill < POOL_DEPTH) recent_fill++;
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_banks(logic [15:0] irq, logic en, logic [15:0] prog,
                                logic [15:0] data, logic [15:0] b);
      wait_drained();
      write_reg(CSR_IRQ_BANK, irq);
      write_reg(CSR_IRQ_ENABLE, {15'($urandom), en});
      write_reg(CSR_PROGRAM_BANK, prog);
      write_reg(CSR_DATA_BANK, data);
      write_reg(CSR_B_BANK, b);
      write_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_bank();
      case ($urandom_range(4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // a third of the time revisit a recent address, sometimes through the
   // aliasing window (bit 15 flipped) so RAM contents get read back
   function automatic logic [15:0] pick_address();
      logic [15:0] a;
      int          roll;
      roll = $urandom_range(99);
      if (recent_fill > 0 && roll < 35) begin
         a = recent_addr[$urandom_range(recent_fill - 1)];
         if ($urandom_range(3) == 0) a[15] = ~a[15];
      end else begin
         roll = $urandom_range(99);
         if (roll < 10)      a = 16'($urandom_range(16'h007F));
         else if (roll < 28) a = 16'($urandom_range(16'h1FFF, 16'h0080));
         else if (roll < 48) a = 16'($urandom_range(16'h3FFF, 16'h2000));
         else if (roll < 72) a = 16'($urandom_range(16'h7FFF, 16'h4000));
         else                a = 16'($urandom_range(16'hFFFF, 16'h8000));
      end
      return a;
   endfunction

   task automatic run_phase(int items, int gap_pct);
      repeat (items) begin
         send_access(1'($urandom_range(1)), pick_address(), 8'($urandom),
                     1'($urandom_range(1)));
         if ($urandom_range(63) == 0) begin
            wait_drained();
         end else begin
            // each cycle idles with the phase's odds
            while ($urandom_range(99) < gap_pct) begin
               start <= 1'b0;
               @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset banks: every window external at page zero
      send_access(CMD_READ,  16'h9234, 8'h00, 1'b0);
      send_access(CMD_WRITE, 16'h5678, 8'h3C, 1'b1);

      // widest external pages but program page zero; data page spills past the address width
      program_banks(16'h7FFF, 1'b1, 16'h0000, 16'h7FFF, 16'h7FFF);
      send_access(CMD_READ,  16'h0000, 8'h11, 1'b0);
      send_access(CMD_WRITE, 16'h007F, 8'hEE, 1'b1);
      send_access(CMD_WRITE, 16'h0080, 8'hA5, 1'b0);
      send_access(CMD_READ,  16'h0080, 8'h00, 1'b0);
      send_access(CMD_WRITE, 16'h1FFF, 8'hFF, 1'b0);
      send_access(CMD_READ,  16'h1FFF, 8'h00, 1'b1);
      send_access(CMD_READ,  16'h2000, 8'h00, 1'b0);
      send_access(CMD_WRITE, 16'h3FFF, 8'h77, 1'b0);
      send_access(CMD_READ,  16'h4000, 8'h00, 1'b0);
      send_access(CMD_WRITE, 16'h7FFF, 8'h42, 1'b1);
      send_access(CMD_READ,  16'h8000, 8'h00, 1'b0);
      send_access(CMD_WRITE, 16'hFFFF, 8'h99, 1'b1);

      // all windows internal; unimplemented bank bits written as ones
      program_banks(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_access(CMD_WRITE, 16'hFFFF, 8'h5A, 1'b0);
      send_access(CMD_READ,  16'h7FFF, 8'h00, 1'b1);
      send_access(CMD_WRITE, 16'h3FFF, 8'h81, 1'b0);
      send_access(CMD_READ,  16'hBFFF, 8'h00, 1'b0);
      send_access(CMD_READ,  16'h9FFF, 8'h00, 1'b0);
      send_access(CMD_READ,  16'h4000, 8'h00, 1'b1);

      for (int p = 0; p < 6; p++) begin
         program_banks(pick_bank(), 1'($urandom_range(1)), pick_bank(), pick_bank(),
                       pick_bank());
         run_phase(125, idle_pct[p / 2]);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("banked_window_address_translator_unit_tb OK");
      else
         $display("banked_window_address_translator_unit_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/bwat_pkg.sv
design/bwat_decode.sv
design/banked_window_address_translator_unit.sv
design/bwat_checker.sv
verif/banked_window_address_translator_unit_checker.sv
verif/banked_window_address_translator_unit_tb.sv
